### design/grsd_pkg.sv
// grsd_pkg: shared types, constants and codes for the Golomb-Rice set decoder.
// Depends on nothing; every module in the design imports it.
`default_nettype none

package grsd_pkg;

  // rice parameter: number of remainder bits per code
  localparam int unsigned RICE_BITS = 19;
  localparam int unsigned REM_CNT_W = $clog2(RICE_BITS + 1);

  // compact-size varint prefixes and their body lengths
  localparam logic [7:0] PREFIX_U16 = 8'hfd;
  localparam logic [7:0] PREFIX_U32 = 8'hfe;
  localparam logic [3:0] LEN_U16    = 4'd2;
  localparam logic [3:0] LEN_U32    = 4'd4;
  localparam logic [3:0] LEN_U64    = 4'd8;

  // queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // work handed from front end to back end
  typedef enum logic [2:0] {
    OP_CODE,   // code byte, decode its bits
    OP_START,  // header finished, count within capacity and nonzero
    OP_EMPTY,  // header finished, empty set
    OP_OVER,   // header count above capacity
    OP_TRUNC   // filter ended inside the varint
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [31:0] total;
    logic        last;
  } entry_t;

  typedef enum logic [1:0] {
    FS_PREFIX,
    FS_VARINT,
    FS_BODY
  } front_state_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_UNARY,
    PH_REM,
    PH_DONE,
    PH_FAIL
  } phase_t;

  // extra result still owed by the byte in work
  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_DONE,
    PEND_ERR
  } pend_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] set_value;
    logic [31:0] element_index;
    logic        last_of_run;
  } result_t;

endpackage

`default_nettype wire

### design/grsd_in_if.sv
// grsd_in_if: filter byte channel, valid/ready handshake.
// Standalone; used by the top level and the front end.
`default_nettype none

interface grsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filter_byte;
  logic       final_byte;

  modport source (output valid, output filter_byte, output final_byte, input ready);
  modport sink (input valid, input filter_byte, input final_byte, output ready);
endinterface

`default_nettype wire

### design/grsd_out_if.sv
// grsd_out_if: decoded result channel, valid/ready handshake.
// Standalone; used by the top level and the back end.
`default_nettype none

interface grsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] set_value;
  logic [31:0] element_index;
  logic        last_of_run;

  modport source (output valid, output kind, output set_value, output element_index,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input set_value, input element_index,
                input last_of_run, output ready);
endinterface

`default_nettype wire

### design/grsd_cfg_if.sv
// grsd_cfg_if: capacity register write channel, valid/ready handshake.
// Standalone; used by the top level and the front end.
`default_nettype none

interface grsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### design/golomb_rice_set_decoder_unit.sv
// golomb_rice_set_decoder_unit: top level of the Golomb-Rice coded set decoder.
// Depends on grsd_pkg, the channel interfaces, grsd_front, grsd_queue, grsd_back.
//
// Decodes a BIP158-style Golomb-Rice coded set fed one byte per request. A
// front end takes a byte in every cycle while its 4-entry work queue has room,
// parses the compact-size count and checks it against the capacity register;
// varint body bytes give the back end no work, save the last one and a final
// one that cuts the count short. The back end walks each code byte at one bit
// per cycle while its results can move on; a done or final error result that
// follows a value on the same byte takes a step of its own. Results leave
// through a hold stage (which sets last_of_run) and an output register, so
// decoding continues while a result waits to be taken. Capacity may be
// written at any time the block is idle and survives the rearm done by each
// final byte.
`default_nettype none

module golomb_rice_set_decoder_unit import grsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  grsd_in_if.sink     filter,
  grsd_out_if.source  result,
  grsd_cfg_if.sink    setup
);

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   avail;
  entry_t pop_entry;

  // byte intake and header parsing
  grsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .filter     (filter),
    .setup      (setup),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  // decoupling queue
  grsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .avail      (avail),
    .pop_entry  (pop_entry)
  );

  // bit-serial code decoding
  grsd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (avail),
    .q_entry (pop_entry),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

### design/grsd_front.sv
// grsd_front: accepts filter bytes, parses the varint count, checks capacity
// and hands classified work to the queue. Depends on grsd_pkg and the interfaces.
`default_nettype none

module grsd_front import grsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  grsd_in_if.sink     filter,
  grsd_cfg_if.sink    setup,
  output logic        push,
  output entry_t      push_entry,
  input  logic        full
);

  front_state_t state, state_next;
  logic [31:0]  capacity;
  logic [63:0]  acc;
  logic [2:0]   vpos;
  logic [3:0]   vleft;

  logic         accept;
  logic         short_prefix;
  logic         body_end;
  logic [63:0]  lane_acc;
  logic [63:0]  hdr_total;
  logic         over;
  op_t          hdr_op;

  // capacity register, always writable
  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '1;
    end else if (setup.valid) begin
      capacity <= setup.capacity;
    end
  end

  // request accepted whenever the queue has room
  assign filter.ready = !full;
  assign accept       = filter.valid && !full;

  // header classification
  always_comb begin
    short_prefix = filter.filter_byte < PREFIX_U16;
    body_end     = vleft == 4'd1;
    lane_acc     = acc | ({56'b0, filter.filter_byte} << {vpos, 3'b000});
    hdr_total    = (state == FS_PREFIX) ? {56'b0, filter.filter_byte} : lane_acc;
    over         = (hdr_total[63:32] != 32'b0) || (hdr_total[31:0] > capacity);
    if (over) begin
      hdr_op = OP_OVER;
    end else if (hdr_total == 64'b0) begin
      hdr_op = OP_EMPTY;
    end else begin
      hdr_op = OP_START;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (accept) begin
      unique case (state)
        FS_PREFIX: begin
          if (filter.final_byte) state_next = FS_PREFIX;
          else if (short_prefix) state_next = FS_BODY;
          else                   state_next = FS_VARINT;
        end
        FS_VARINT: begin
          if (filter.final_byte) state_next = FS_PREFIX;
          else if (body_end)     state_next = FS_BODY;
          else                   state_next = FS_VARINT;
        end
        FS_BODY: begin
          state_next = filter.final_byte ? FS_PREFIX : FS_BODY;
        end
        default: state_next = FS_PREFIX;
      endcase
    end
  end

  // queue writes
  always_comb begin
    push             = 1'b0;
    push_entry.op    = OP_CODE;
    push_entry.data  = filter.filter_byte;
    push_entry.total = hdr_total[31:0];
    push_entry.last  = filter.final_byte;
    unique case (state)
      FS_PREFIX: begin
        if (short_prefix) begin
          push          = accept;
          push_entry.op = hdr_op;
        end else if (filter.final_byte) begin
          push          = accept;
          push_entry.op = OP_TRUNC;
        end
      end
      FS_VARINT: begin
        if (body_end) begin
          push          = accept;
          push_entry.op = hdr_op;
        end else if (filter.final_byte) begin
          push          = accept;
          push_entry.op = OP_TRUNC;
        end
      end
      FS_BODY: begin
        push = accept;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_PREFIX;
    end else begin
      state <= state_next;
    end
  end

  // varint body accumulation
  always_ff @(posedge clk) begin
    if (accept && state == FS_PREFIX) begin
      acc  <= '0;
      vpos <= '0;
      if (filter.filter_byte == PREFIX_U16)      vleft <= LEN_U16;
      else if (filter.filter_byte == PREFIX_U32) vleft <= LEN_U32;
      else                                       vleft <= LEN_U64;
    end else if (accept && state == FS_VARINT) begin
      acc   <= lane_acc;
      vpos  <= vpos + 3'd1;
      vleft <= vleft - 4'd1;
    end
  end

endmodule

`default_nettype wire

### design/grsd_queue.sv
// grsd_queue: short fifo of classified work between front and back end.
// Depends on grsd_pkg.
`default_nettype none

module grsd_queue import grsd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   avail,
  output entry_t pop_entry
);

  entry_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr;
  logic [QUEUE_AW-1:0]   rptr;
  logic [QUEUE_CW-1:0]   fill;

  assign full      = fill == QUEUE_CW'(QUEUE_DEPTH);
  assign avail     = fill != '0;
  assign pop_entry = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + QUEUE_AW'(1);
      if (pop)  rptr <= rptr + QUEUE_AW'(1);
      if (push && !pop)      fill <= fill + QUEUE_CW'(1);
      else if (pop && !push) fill <= fill - QUEUE_CW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

endmodule

`default_nettype wire

### design/grsd_back.sv
// grsd_back: decodes code bytes one bit per cycle unless stalled, keeps the running
// sum, issues results via a hold stage and output register. Depends on grsd_pkg.
`default_nettype none

module grsd_back import grsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  entry_t     q_entry,
  output logic       pop,
  grsd_out_if.source result
);

  // work in progress
  logic                  busy;
  entry_t                cur;
  logic [2:0]            bit_idx;
  pend_t                 pend;
  phase_t                phase;
  logic [31:0]           total;
  logic [31:0]           count;
  logic [63:0]           sum;
  logic [63:0]           quot;
  logic [RICE_BITS-1:0]  acc;
  logic [REM_CNT_W-1:0]  left;

  // hold stage and output register
  logic                  p_valid;
  logic                  p_sealed;
  result_t               p_res;
  logic                  out_valid;
  result_t               out_res;

  // step outputs
  logic                  gen;
  logic                  gen_sealed;
  result_t               gen_res;
  logic                  seal_p;
  logic                  finish;
  phase_t                phase_next;
  pend_t                 pend_next;
  logic [2:0]            bit_next;
  logic [31:0]           total_next;
  logic [31:0]           count_next;
  logic [63:0]           sum_next;
  logic [63:0]           quot_next;
  logic [RICE_BITS-1:0]  acc_next;
  logic [REM_CNT_W-1:0]  left_next;

  logic                  can_push;
  logic                  step_fire;
  logic                  p_leaves;

  // one step of the decoder
  always_comb begin
    logic              cur_bit;
    logic [RICE_BITS:0] acc_shift;
    logic [63:0]       code_sum;
    logic [31:0]       count_inc;

    cur_bit    = cur.data[bit_idx];
    acc_shift  = {acc, cur_bit};
    code_sum   = sum + {quot[63-RICE_BITS:0], acc_shift[RICE_BITS-1:0]};
    count_inc  = count + 32'd1;

    gen        = 1'b0;
    gen_sealed = 1'b0;
    gen_res    = '0;
    seal_p     = 1'b0;
    finish     = 1'b0;
    phase_next = phase;
    pend_next  = pend;
    bit_next   = bit_idx;
    total_next = total;
    count_next = count;
    sum_next   = sum;
    quot_next  = quot;
    acc_next   = acc;
    left_next  = left;

    if (busy) begin
      unique case (pend)
        PEND_DONE: begin
          gen                   = 1'b1;
          gen_sealed            = 1'b1;
          gen_res.kind          = KIND_DONE;
          gen_res.element_index = count;
          phase_next            = PH_DONE;
          finish                = 1'b1;
        end
        PEND_ERR: begin
          gen          = 1'b1;
          gen_sealed   = 1'b1;
          gen_res.kind = KIND_ERROR;
          finish       = 1'b1;
        end
        PEND_NONE: begin
          unique case (cur.op)
            OP_OVER, OP_TRUNC: begin
              gen          = 1'b1;
              gen_sealed   = 1'b1;
              gen_res.kind = KIND_ERROR;
              phase_next   = PH_FAIL;
              finish       = 1'b1;
            end
            OP_EMPTY: begin
              gen          = 1'b1;
              gen_sealed   = 1'b1;
              gen_res.kind = KIND_DONE;
              phase_next   = PH_DONE;
              finish       = 1'b1;
            end
            OP_START: begin
              phase_next = PH_UNARY;
              total_next = cur.total;
              count_next = '0;
              sum_next   = '0;
              quot_next  = '0;
              acc_next   = '0;
              finish     = 1'b1;
              // filter ends right after its header
              if (cur.last) begin
                gen          = 1'b1;
                gen_sealed   = 1'b1;
                gen_res.kind = KIND_ERROR;
              end
            end
            OP_CODE: begin
              if (phase == PH_UNARY || phase == PH_REM) begin
                // consume one bit, msb first
                if (phase == PH_UNARY) begin
                  if (cur_bit) begin
                    quot_next = quot + 64'd1;
                  end else begin
                    phase_next = PH_REM;
                    acc_next   = '0;
                    left_next  = REM_CNT_W'(RICE_BITS);
                  end
                end else begin
                  acc_next  = acc_shift[RICE_BITS-1:0];
                  left_next = left - REM_CNT_W'(1);
                  if (left == REM_CNT_W'(1)) begin
                    gen                   = 1'b1;
                    gen_res.kind          = KIND_VALUE;
                    gen_res.set_value     = code_sum;
                    gen_res.element_index = count;
                    sum_next              = code_sum;
                    count_next            = count_inc;
                    quot_next             = '0;
                    acc_next              = '0;
                    phase_next            = PH_UNARY;
                    if (count_inc == total) pend_next = PEND_DONE;
                  end
                end
                // end of byte
                if (pend_next != PEND_DONE) begin
                  if (bit_idx == 3'd0) begin
                    if (cur.last && (phase_next == PH_UNARY || phase_next == PH_REM)) begin
                      if (gen) begin
                        pend_next = PEND_ERR;
                      end else begin
                        gen          = 1'b1;
                        gen_sealed   = 1'b1;
                        gen_res.kind = KIND_ERROR;
                        finish       = 1'b1;
                      end
                    end else begin
                      if (gen) gen_sealed = 1'b1;
                      else     seal_p     = 1'b1;
                      finish = 1'b1;
                    end
                  end else begin
                    bit_next = bit_idx - 3'd1;
                  end
                end
              end else begin
                // set finished or failed: byte is ignored
                seal_p = 1'b1;
                finish = 1'b1;
              end
            end
            default: finish = 1'b1;
          endcase
        end
        default: finish = 1'b1;
      endcase
    end
  end

  // handshake between step, hold stage and output register
  assign can_push  = !out_valid || result.ready;
  assign step_fire = busy && !(gen && p_valid && !can_push);
  assign p_leaves  = p_valid && can_push && (p_sealed || (step_fire && gen));
  assign pop       = avail && (!busy || (step_fire && finish));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_idx <= '0;
      pend    <= PEND_NONE;
      phase   <= PH_HEADER;
    end else begin
      if (step_fire) begin
        phase <= (finish && cur.last) ? PH_HEADER : phase_next;
      end
      // a newly taken byte starts at its msb
      if (pop) begin
        busy    <= 1'b1;
        bit_idx <= 3'd7;
        pend    <= PEND_NONE;
      end else if (step_fire) begin
        pend    <= finish ? PEND_NONE : pend_next;
        bit_idx <= bit_next;
        if (finish) busy <= 1'b0;
      end
    end
  end

  // decoder datapath
  always_ff @(posedge clk) begin
    if (pop) cur <= q_entry;
    if (step_fire) begin
      total <= total_next;
      count <= count_next;
      sum   <= sum_next;
      quot  <= quot_next;
      acc   <= acc_next;
      left  <= left_next;
    end
  end

  // hold stage: keeps the newest result until the byte's last one is known
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      p_sealed <= 1'b0;
    end else begin
      p_valid <= (p_valid && !p_leaves) || (step_fire && gen);
      if (step_fire && gen)         p_sealed <= gen_sealed;
      else if (step_fire && seal_p) p_sealed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && gen) p_res <= gen_res;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p_leaves || (out_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (p_leaves) begin
      out_res <= {p_res.kind, p_res.set_value, p_res.element_index, p_sealed};
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_res.kind;
  assign result.set_value     = out_res.set_value;
  assign result.element_index = out_res.element_index;
  assign result.last_of_run   = out_res.last_of_run;

endmodule

`default_nettype wire

### design/grsd_checker.sv
// grsd_checker: port-level checks on the result channel of the set decoder.
// Depends on grsd_pkg; bound to golomb_rice_set_decoder_unit below.
`default_nettype none

module grsd_checker import grsd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_kind,
  input logic [63:0] res_value,
  input logic [31:0] res_index,
  input logic        res_last
);

  // a stalled result request stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  // a stalled result request keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_kind) && $stable(res_value) &&
                                $stable(res_index) && $stable(res_last))
    else $error("result payload changed while stalled");

  // only defined kinds appear
  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_kind == KIND_VALUE || res_kind == KIND_DONE || res_kind == KIND_ERROR)
    else $error("undefined result kind");

  // done and error carry no sum and always close the byte's run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != KIND_VALUE |-> res_value == 64'd0 && res_last)
    else $error("status result with sum or without last flag");

  // errors carry index zero
  a_error_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_ERROR |-> res_index == 32'd0)
    else $error("error result with nonzero index");

endmodule

bind golomb_rice_set_decoder_unit grsd_checker u_grsd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_kind  (result.kind),
  .res_value (result.set_value),
  .res_index (result.element_index),
  .res_last  (result.last_of_run)
);

`default_nettype wire

### verif/golomb_rice_set_decoder_unit_tb.sv
`timescale 1ns / 100ps
// golomb_rice_set_decoder_unit_tb: self-checking bench for the Golomb-Rice set decoder.
// Depends on grsd_pkg, the grsd channel interfaces and golomb_rice_set_decoder_unit.
// Encodes filters, predicts every result in a bit-level decoder and checks them in order.

module golomb_rice_set_decoder_unit_tb;
  import grsd_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [7:0]  PREFIX_U64    = 8'hff;
  localparam logic [31:0] CAP_MAX       = 32'hffff_ffff;
  localparam logic [31:0] REM_ONES      = (32'd1 << RICE_BITS) - 32'd1;

  typedef enum logic [2:0] {
    DEC_PREFIX,
    DEC_VARINT,
    DEC_UNARY,
    DEC_REM,
    DEC_DONE,
    DEC_FAIL
  } dec_phase_t;

  typedef enum int unsigned {
    FORM_BYTE,
    FORM_U16,
    FORM_U32,
    FORM_U64
  } hdr_form_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  grsd_in_if  filter_ch ();
  grsd_out_if result_ch ();
  grsd_cfg_if setup_ch ();

  golomb_rice_set_decoder_unit uut (
    .clk    (clk),
    .rst    (rst),
    .filter (filter_ch),
    .result (result_ch),
    .setup  (setup_ch)
  );

  // decoder model state
  logic [31:0] cap_reg;
  dec_phase_t  dec_phase;
  logic [3:0]  hdr_left;
  logic [3:0]  hdr_pos;
  logic [63:0] set_size;
  logic [31:0] decoded_count;
  logic [63:0] sum_acc;
  logic [63:0] unary_run;
  logic [31:0] rem_bits;
  logic [5:0]  rem_left;

  result_t     step_results[$];
  result_t     owed_results[$];
  result_t     seen_result;
  result_t     want_result;

  // filter under construction
  logic [7:0]  filter_bytes[$];
  int unsigned code_quot[$];
  logic [31:0] code_rem[$];

  bit          idle_on;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned live_items;
  int unsigned mismatches;
  int unsigned cycles;

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void rearm_decoder();
    dec_phase     = DEC_PREFIX;
    hdr_left      = '0;
    hdr_pos       = '0;
    set_size      = '0;
    decoded_count = '0;
    sum_acc       = '0;
    unary_run     = '0;
    rem_bits      = '0;
    rem_left      = '0;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [63:0] val, logic [31:0] idx);
    result_t r;
    r.kind          = kind;
    r.set_value     = val;
    r.element_index = idx;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // count known: refuse it, finish an empty set, or start on the codes
  function automatic void finish_header();
    decoded_count = '0;
    if (set_size > {32'b0, cap_reg}) begin
      step_results.push_back(make_result(KIND_ERROR, '0, '0));
      dec_phase = DEC_FAIL;
    end else if (set_size == 64'd0) begin
      step_results.push_back(make_result(KIND_DONE, '0, '0));
      dec_phase = DEC_DONE;
    end else begin
      dec_phase = DEC_UNARY;
    end
  endfunction

  // msb first: unary quotient, stop bit, then the fixed remainder
  function automatic void walk_code_bits(logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      if (dec_phase == DEC_UNARY) begin
        if (b[i]) begin
          unary_run = unary_run + 64'd1;
        end else begin
          dec_phase = DEC_REM;
          rem_bits  = '0;
          rem_left  = 6'(RICE_BITS);
        end
      end else if (dec_phase == DEC_REM) begin
        rem_bits = {rem_bits[30:0], b[i]};
        rem_left = rem_left - 6'd1;
        if (rem_left == 6'd0) begin
          sum_acc = sum_acc + (unary_run << RICE_BITS) + {32'b0, rem_bits};
          step_results.push_back(make_result(KIND_VALUE, sum_acc, decoded_count));
          decoded_count = decoded_count + 32'd1;
          unary_run     = '0;
          rem_bits      = '0;
          dec_phase     = DEC_UNARY;
          if ({32'b0, decoded_count} == set_size) begin
            step_results.push_back(make_result(KIND_DONE, '0, decoded_count));
            dec_phase = DEC_DONE;
          end
        end
      end
    end
  endfunction

  // one accepted byte: queue every result it owes
  function automatic void decode_byte(logic [7:0] b, logic fin);
    step_results.delete();
    case (dec_phase)
      DEC_PREFIX: begin
        if (b < PREFIX_U16) begin
          set_size = {56'b0, b};
          finish_header();
        end else begin
          hdr_left  = (b == PREFIX_U16) ? LEN_U16 : (b == PREFIX_U32) ? LEN_U32 : LEN_U64;
          hdr_pos   = '0;
          set_size  = '0;
          dec_phase = DEC_VARINT;
        end
      end
      DEC_VARINT: begin
        set_size = set_size | ({56'b0, b} << (hdr_pos[2:0] * 8));
        hdr_pos  = hdr_pos + 4'd1;
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) finish_header();
      end
      DEC_UNARY, DEC_REM: walk_code_bits(b);
      default: ;
    endcase
    if (fin) begin
      if (dec_phase != DEC_DONE && dec_phase != DEC_FAIL)
        step_results.push_back(make_result(KIND_ERROR, '0, '0));
      rearm_decoder();
    end
    if (step_results.size() != 0)
      step_results[step_results.size() - 1].last_of_run = 1'b1;
    foreach (step_results[k]) owed_results.push_back(step_results[k]);
  endfunction

  // ---------------------------------------------------------------- encoding

  function automatic hdr_form_t pick_form(logic [63:0] count);
    hdr_form_t least;
    if (count < 64'd253) least = FORM_BYTE;
    else if (count < 64'h1_0000) least = FORM_U16;
    else if (count < 64'h1_0000_0000) least = FORM_U32;
    else least = FORM_U64;
    if ($urandom_range(3) == 0)
      least = hdr_form_t'($urandom_range(int'(least), int'(FORM_U64)));
    return least;
  endfunction

  // header plus all queued codes, padded to a byte boundary
  function automatic void encode_filter(logic [63:0] count, hdr_form_t form, bit pad_bit);
    bit bits[$];
    int unsigned body;
    body = 0;
    filter_bytes.delete();
    case (form)
      FORM_BYTE: filter_bytes.push_back(count[7:0]);
      FORM_U16: begin
        filter_bytes.push_back(PREFIX_U16);
        body = LEN_U16;
      end
      FORM_U32: begin
        filter_bytes.push_back(PREFIX_U32);
        body = LEN_U32;
      end
      default: begin
        filter_bytes.push_back(PREFIX_U64);
        body = LEN_U64;
      end
    endcase
    for (int k = 0; k < body; k++) filter_bytes.push_back(count[8 * k +: 8]);
    foreach (code_quot[c]) begin
      repeat (code_quot[c]) bits.push_back(1'b1);
      bits.push_back(1'b0);
      for (int k = RICE_BITS - 1; k >= 0; k--) bits.push_back(code_rem[c][k]);
    end
    while (bits.size() % 8 != 0) bits.push_back(pad_bit);
    for (int k = 0; k < bits.size(); k += 8)
      filter_bytes.push_back({bits[k], bits[k + 1], bits[k + 2], bits[k + 3],
                              bits[k + 4], bits[k + 5], bits[k + 6], bits[k + 7]});
  endfunction

  // mostly short quotients, a few long runs of ones
  function automatic void fill_random_codes(int unsigned n);
    int unsigned pick;
    code_quot.delete();
    code_rem.delete();
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 80) code_quot.push_back($urandom_range(0, 2));
      else if (pick < 95) code_quot.push_back($urandom_range(3, 12));
      else code_quot.push_back($urandom_range(13, 40));
      pick = $urandom_range(99);
      if (pick < 10) code_rem.push_back('0);
      else if (pick < 20) code_rem.push_back(REM_ONES);
      else code_rem.push_back($urandom & REM_ONES);
    end
  endfunction

  // ---------------------------------------------------------------- channel drivers

  // send one request on the filter channel and predict on acceptance
  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      filter_ch.valid <= 1'b0;
      @(negedge clk);
    end
    filter_ch.valid       <= 1'b1;
    filter_ch.filter_byte <= b;
    filter_ch.final_byte  <= fin;
    @(posedge clk);
    while (!filter_ch.ready) @(posedge clk);
    if (dec_phase != DEC_DONE && dec_phase != DEC_FAIL) live_items++;
    decode_byte(b, fin);
  endtask

  task automatic send_filter(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) send_byte(filter_bytes[k], k == len - 1);
  endtask

  // drop valid, drain all owed results, let the back end finish silent bytes
  task automatic settle();
    @(negedge clk);
    filter_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] value);
    settle();
    @(negedge clk);
    setup_ch.valid    <= 1'b1;
    setup_ch.capacity <= value;
    @(posedge clk);
    while (!setup_ch.ready) @(posedge clk);
    cap_reg = value;
    @(negedge clk);
    setup_ch.valid <= 1'b0;
  endtask

  // well-formed filters, some with trailing bytes, cut-short filters and raw noise
  task automatic send_random_filter();
    int unsigned pick, count, len;
    pick = $urandom_range(99);
    if (pick < 85) begin
      count = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
      fill_random_codes(count);
      encode_filter(count, pick_form(count), 1'($urandom_range(1)));
      if (pick < 70 && $urandom_range(4) == 0)
        repeat ($urandom_range(1, 3)) filter_bytes.push_back(8'($urandom_range(255)));
      len = filter_bytes.size();
      if (pick >= 70) len = $urandom_range(1, len);
    end else begin
      len = $urandom_range(1, 6);
      filter_bytes.delete();
      repeat (len) filter_bytes.push_back(8'($urandom_range(255)));
    end
    send_filter(len);
  endtask

  // ---------------------------------------------------------------- result side

  // receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      result_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen_result.kind          = result_ch.kind;
      seen_result.set_value     = result_ch.set_value;
      seen_result.element_index = result_ch.element_index;
      seen_result.last_of_run   = result_ch.last_of_run;
      if (owed_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: kind %0d value %h index %0d last %b",
                   seen_result.kind, seen_result.set_value, seen_result.element_index,
                   seen_result.last_of_run);
        mismatches++;
      end else begin
        want_result = owed_results.pop_front();
        if (seen_result !== want_result) begin
          if (mismatches < MAX_REPORTS)
            $display("result mismatch: expected kind %0d value %h index %0d last %b, got kind %0d value %h index %0d last %b",
                     want_result.kind, want_result.set_value, want_result.element_index,
                     want_result.last_of_run, seen_result.kind, seen_result.set_value,
                     seen_result.element_index, seen_result.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // empty set, and a byte after done that only rearms
  task automatic test_empty_and_trailing();
    filter_bytes = '{8'h00};
    send_filter(1);
    filter_bytes = '{8'h00, 8'hab};
    send_filter(2);
  endtask

  // final byte inside the varint body, and on a bare long prefix
  task automatic test_truncated_header();
    filter_bytes = '{8'hfd, 8'h05};
    send_filter(2);
    filter_bytes = '{PREFIX_U64};
    send_filter(1);
  endtask

  // remainder extremes, trailing pad ones, and a stream that ends short
  task automatic test_code_extremes();
    code_quot = '{0, 3};
    code_rem  = '{REM_ONES, 32'd0};
    encode_filter(64'd2, FORM_BYTE, 1'b1);
    send_filter(filter_bytes.size());
    code_quot = '{0};
    code_rem  = '{32'd0};
    encode_filter(64'd2, FORM_BYTE, 1'b0);
    send_filter(filter_bytes.size());
  endtask

  // capacity at both ends
  task automatic test_capacity_limits();
    write_capacity(32'd0);
    filter_bytes = '{8'h00};
    send_filter(1);
    filter_bytes = '{8'h01};
    send_filter(1);
    write_capacity(CAP_MAX);
    // largest 32-bit count fits, the filter then ends with no codes
    code_quot.delete();
    code_rem.delete();
    encode_filter(64'h0000_0000_ffff_ffff, FORM_U32, 1'b0);
    send_filter(filter_bytes.size());
    // count past 32 bits is refused
    encode_filter(64'h0000_0001_0000_0000, FORM_U64, 1'b0);
    send_filter(filter_bytes.size());
  endtask

  task automatic test_random_filters(input int unsigned items);
    int unsigned goal;
    goal = live_items + items;
    while (live_items < goal) send_random_filter();
  endtask

  // no idling on either side, small capacity so refusals are common
  task automatic test_steady_flow(input int unsigned items);
    write_capacity(32'($urandom_range(2, 6)));
    idle_on = 1'b0;
    test_random_filters(items);
    idle_on = 1'b1;
  endtask

  // long receiver hold while a big filter keeps coming
  task automatic test_backpressure(input int unsigned items);
    write_capacity(CAP_MAX);
    fill_random_codes(24);
    encode_filter(64'd24, FORM_BYTE, 1'b0);
    send_byte(filter_bytes[0], 1'b0);
    hold_request = 1'b1;
    for (int unsigned k = 1; k < filter_bytes.size(); k++)
      send_byte(filter_bytes[k], k == filter_bytes.size() - 1);
    test_random_filters(items);
  endtask

  initial begin
    filter_ch.valid       = 1'b0;
    filter_ch.filter_byte = '0;
    filter_ch.final_byte  = 1'b0;
    setup_ch.valid        = 1'b0;
    setup_ch.capacity     = '0;
    result_ch.ready       = 1'b0;
    idle_on               = 1'b1;
    hold_request          = 1'b0;
    hold_left             = 0;
    live_items            = 0;
    mismatches            = 0;
    cycles                = 0;
    cap_reg               = CAP_MAX;
    rearm_decoder();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_trailing();
    test_truncated_header();
    test_code_extremes();
    test_capacity_limits();
    test_random_filters(200);
    test_steady_flow(150);
    test_backpressure(150);

    settle();
    if (mismatches == 0 && owed_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
design/grsd_pkg.sv
design/grsd_in_if.sv
design/grsd_out_if.sv
design/grsd_cfg_if.sv
design/grsd_front.sv
design/grsd_queue.sv
design/grsd_back.sv
design/golomb_rice_set_decoder_unit.sv
design/grsd_checker.sv
verif/golomb_rice_set_decoder_unit_tb.sv
